// ===== rtl/bpc_pkg.sv =====
// types and constants shared by the button press classifier
package bpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 8;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } press_event_e;

  localparam logic [IdxW-1:0] REG_DEBOUNCE  = 8'd0;
  localparam logic [IdxW-1:0] REG_LONG      = 8'd1;
  localparam logic [IdxW-1:0] REG_REPEAT    = 8'd2;
  localparam logic [IdxW-1:0] REG_OVERPRESS = 8'd3;

  localparam logic [CfgW-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CfgW-1:0] LONG_RST      = 16'd900;
  localparam logic [CfgW-1:0] REPEAT_RST    = 16'd200;
  localparam logic [CfgW-1:0] OVERPRESS_RST = 16'd3000;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_ms;
    logic [CfgW-1:0] repeat_ms;
    logic [CfgW-1:0] overpress_ms;
  } cfg_t;

endpackage

// ===== rtl/bpc_if.sv =====
// valid/ready channel interfaces for polls, results and register writes
interface bpc_in_if import bpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_ms;
  logic             button_down;

  modport source (output valid, now_ms, button_down, input ready);
  modport sink   (input valid, now_ms, button_down, output ready);
endinterface

interface bpc_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] press_event;
  logic       repeat_tick;

  modport source (output valid, press_event, repeat_tick, input ready);
  modport sink   (input valid, press_event, repeat_tick, output ready);
endinterface

interface bpc_cfg_if import bpc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] index;
  logic [CfgW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bpc_cfg_regs.sv =====
// configuration register file with index decode
module bpc_cfg_regs import bpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpc_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (cfg_i.index)
        REG_DEBOUNCE:  cfg_d.debounce_ms  = cfg_i.data;
        REG_LONG:      cfg_d.long_ms      = cfg_i.data;
        REG_REPEAT:    cfg_d.repeat_ms    = cfg_i.data;
        REG_OVERPRESS: cfg_d.overpress_ms = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms  <= DEBOUNCE_RST;
      cfg_q.long_ms      <= LONG_RST;
      cfg_q.repeat_ms    <= REPEAT_RST;
      cfg_q.overpress_ms <= OVERPRESS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/button_press_classifier.sv =====
// button press classifier: poll register, evaluation logic, result register
// an accepted poll waits in the poll register, then moves on to the result register when free
// throughput: one poll per cycle when not stalled; held state and times update as a poll
// moves to the result; a stalled result register holds the poll register, which can still
// take one more word; reset clears held, press start and last repeat to zero and loads
// register defaults (debounce 50, long 900, repeat 200, overpress 3000); both stages come out empty
module button_press_classifier import bpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpc_in_if.sink    in_i,
  bpc_out_if.source out_o,
  bpc_cfg_if.sink   cfg_i
);

  cfg_t cfg;

  bpc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // poll register
  logic             in_vld_q, in_vld_d;
  logic [TimeW-1:0] now_q;
  logic             down_q;

  // result register
  logic         out_vld_q;
  press_event_e evt_q, evt_d;
  logic         tick_q, tick_d;

  // press state
  logic             held_q, held_d;
  logic [TimeW-1:0] press_start_q, press_start_d;
  logic [TimeW-1:0] last_repeat_q, last_repeat_d;

  logic             advance, accept, fire;
  logic [TimeW-1:0] elapsed, since_rep;
  logic             restart;

  assign advance    = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || advance;
  assign accept     = in_i.valid && in_i.ready;
  assign fire       = in_vld_q && advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  assign elapsed   = now_q - press_start_q;
  assign since_rep = now_q - last_repeat_q;
  // a new press or an over-long hold starts timing again from now
  assign restart   = !held_q || (elapsed > {{(TimeW-CfgW){1'b0}}, cfg.overpress_ms});

  always_comb begin
    evt_d  = EVT_NONE;
    tick_d = down_q && !restart
             && (elapsed > {{(TimeW-CfgW){1'b0}}, cfg.long_ms})
             && (since_rep > {{(TimeW-CfgW){1'b0}}, cfg.repeat_ms});
    if (!down_q && held_q) begin
      if (elapsed < {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms}) begin
        evt_d = EVT_NONE;
      end else if (elapsed > {{(TimeW-CfgW){1'b0}}, cfg.long_ms}) begin
        evt_d = EVT_LONG;
      end else begin
        evt_d = EVT_SHORT;
      end
    end
    held_d        = down_q;
    press_start_d = (down_q && restart) ? now_q : press_start_q;
    if (!down_q) begin
      last_repeat_d = '0;
    end else if (tick_d) begin
      last_repeat_d = now_q;
    end else begin
      last_repeat_d = last_repeat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      held_q        <= 1'b0;
      press_start_q <= '0;
      last_repeat_q <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (fire) begin
        held_q        <= held_d;
        press_start_q <= press_start_d;
        last_repeat_q <= last_repeat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q  <= in_i.now_ms;
      down_q <= in_i.button_down;
    end
    if (fire) begin
      evt_q  <= evt_d;
      tick_q <= tick_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.press_event = evt_q;
  assign out_o.repeat_tick = tick_q;

endmodule

// ===== rtl/bpc_checker.sv =====
// port-level assertions for the button press classifier and their bind
module bpc_checker import bpc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] press_event,
  input logic       repeat_tick
);

  // a result word waiting on the sink keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(press_event) && $stable(repeat_tick))
    else $error("result word changed while stalled");

  a_evt_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> press_event <= EVT_LONG)
    else $error("press event code out of range");

  // a release classifies, a held poll may tick: never both in one word
  a_evt_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && repeat_tick |-> press_event == EVT_NONE)
    else $error("repeat tick together with press event");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .press_event (out_o.press_event),
  .repeat_tick (out_o.repeat_tick)
);

// ===== dv/tb_button_press_classifier.sv =====
`timescale 1ns / 1ps
// testbench for the button press classifier: timed poll sequences checked against a local model
module tb_button_press_classifier;
  import bpc_pkg::*;

  localparam int unsigned ClkPeriod   = 4;
  localparam int unsigned TimeoutNs   = 2_000_000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxPrinted  = 50;

  localparam logic [IdxW-1:0] REG_SPARE_FIRST = REG_OVERPRESS + 8'd1;
  localparam logic [IdxW-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    press_event_e press_event;
    logic         repeat_tick;
  } verdict_t;

  logic clk;
  logic rst_n;

  bpc_in_if  in_if ();
  bpc_out_if out_if ();
  bpc_cfg_if cfg_if ();

  button_press_classifier uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // classifier model state
  cfg_t             model_cfg;
  logic             model_held;
  logic [TimeW-1:0] model_press_start;
  logic [TimeW-1:0] model_last_repeat;

  verdict_t         verdict_q[$];
  int unsigned      mismatch_count;
  int unsigned      polls_sent;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  logic [TimeW-1:0] poll_clock;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  initial begin
    #(TimeoutNs);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void apply_reg_write(input logic [IdxW-1:0] idx,
                                          input logic [CfgW-1:0] value);
    case (idx)
      REG_DEBOUNCE:  model_cfg.debounce_ms  = value;
      REG_LONG:      model_cfg.long_ms      = value;
      REG_REPEAT:    model_cfg.repeat_ms    = value;
      REG_OVERPRESS: model_cfg.overpress_ms = value;
      default: ;
    endcase
  endfunction

  // press start update first, then the repeat decision on the updated state
  function automatic void classify_poll(input logic [TimeW-1:0] now, input logic down);
    logic [TimeW-1:0] held_for;
    verdict_t         v;
    v.press_event = EVT_NONE;
    v.repeat_tick = 1'b0;
    if (down) begin
      if (!model_held) begin
        model_held        = 1'b1;
        model_press_start = now;
      end else if (now - model_press_start > TimeW'(model_cfg.overpress_ms)) begin
        model_press_start = now;
      end
      held_for = now - model_press_start;
      if (held_for > TimeW'(model_cfg.long_ms) &&
          now - model_last_repeat > TimeW'(model_cfg.repeat_ms)) begin
        model_last_repeat = now;
        v.repeat_tick     = 1'b1;
      end
    end else begin
      if (model_held) begin
        held_for   = now - model_press_start;
        model_held = 1'b0;
        if (held_for < TimeW'(model_cfg.debounce_ms)) v.press_event = EVT_NONE;
        else if (held_for > TimeW'(model_cfg.long_ms)) v.press_event = EVT_LONG;
        else v.press_event = EVT_SHORT;
      end
      model_last_repeat = '0;
    end
    verdict_q.push_back(v);
  endfunction

  // one process sees every handshake: results, register writes and polls
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word: event %0d tick %0b",
                                    out_if.press_event, out_if.repeat_tick));
        end else begin
          want = verdict_q.pop_front();
          if (out_if.press_event !== want.press_event)
            report_mismatch($sformatf("press_event %0d, expected %0d",
                                      out_if.press_event, want.press_event));
          if (out_if.repeat_tick !== want.repeat_tick)
            report_mismatch($sformatf("repeat_tick %0b, expected %0b",
                                      out_if.repeat_tick, want.repeat_tick));
        end
      end
      if (cfg_if.valid && cfg_if.ready) apply_reg_write(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) classify_poll(in_if.now_ms, in_if.button_down);
    end
  end

  always @(posedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_poll(input logic [TimeW-1:0] now, input logic down);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.now_ms      <= now;
    in_if.button_down <= down;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    polls_sent++;
  endtask

  // sender holds off until every word in flight has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CfgW-1:0] debounce, input logic [CfgW-1:0] long_t,
                            input logic [CfgW-1:0] rpt, input logic [CfgW-1:0] overpress);
    wait_drained();
    write_reg(REG_DEBOUNCE, debounce);
    write_reg(REG_LONG, long_t);
    write_reg(REG_REPEAT, rpt);
    write_reg(REG_OVERPRESS, overpress);
  endtask

  // time steps aimed at the thresholds, with some wide and wrapping jumps
  function automatic logic [TimeW-1:0] hold_step();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TimeW'(model_cfg.debounce_ms) + TimeW'($urandom_range(0, 2)) - 1;
      2: return TimeW'(model_cfg.long_ms) + TimeW'($urandom_range(0, 2)) - 1;
      3: return TimeW'(model_cfg.repeat_ms) + TimeW'($urandom_range(0, 2)) - 1;
      4: return TimeW'(model_cfg.overpress_ms) + TimeW'($urandom_range(0, 2)) - 1;
      5: return $urandom;
      6: return TimeW'($urandom_range(1, 50));
      default: return TimeW'($urandom_range(0, 2 * model_cfg.long_ms + 2));
    endcase
  endfunction

  task automatic press_sequence();
    logic [TimeW-1:0] t;
    int unsigned      holds;
    t     = poll_clock;
    holds = $urandom_range(0, 6);
    send_poll(t, 1'b1);
    repeat (holds) begin
      t += hold_step();
      send_poll(t, 1'b1);
    end
    t += hold_step();
    send_poll(t, 1'b0);
    poll_clock = t + TimeW'($urandom_range(1, 100));
    if ($urandom_range(3) == 0) send_poll(poll_clock, 1'b0);
  endtask

  // mostly well formed presses, some noise and some drained pauses
  task automatic run_traffic(input int unsigned n_polls);
    int unsigned first;
    first = polls_sent;
    while (polls_sent - first < n_polls) begin
      if ($urandom_range(99) < 80) press_sequence();
      else send_poll($urandom, 1'($urandom_range(0, 1)));
      if ($urandom_range(99) < 4) wait_drained();
    end
  endtask

  task automatic test_directed();
    // release while idle, bottom and top of the time range
    send_poll(32'd0, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b0);
    // bounce shorter than debounce
    send_poll(32'd1000, 1'b1);
    send_poll(32'd1049, 1'b0);
    // exactly debounce gives short
    send_poll(32'd2000, 1'b1);
    send_poll(32'd2050, 1'b0);
    // exactly long is still short, one more is long
    send_poll(32'd3000, 1'b1);
    send_poll(32'd3900, 1'b0);
    send_poll(32'd4000, 1'b1);
    send_poll(32'd4901, 1'b0);
    // repeat ticks need strictly more than the spacing
    send_poll(32'd10000, 1'b1);
    send_poll(32'd10900, 1'b1);
    send_poll(32'd10901, 1'b1);
    send_poll(32'd11101, 1'b1);
    send_poll(32'd11102, 1'b1);
    send_poll(32'd11200, 1'b0);
    // over-press restarts the press start time
    send_poll(32'd20000, 1'b1);
    send_poll(32'd23000, 1'b1);
    send_poll(32'd23001, 1'b1);
    send_poll(32'd23100, 1'b0);
    // press across the wrap, a tick due at time zero looks like no tick yet
    send_poll(32'hFFFF_FC00, 1'b1);
    send_poll(32'd0, 1'b1);
    send_poll(32'd201, 1'b1);
    send_poll(32'd300, 1'b0);
  endtask

  task automatic test_register_settings();
    poll_clock = $urandom;
    set_config('0, '0, '0, '0);
    run_traffic(20);
    set_config('1, '1, '1, '1);
    run_traffic(20);
    set_config('1, '0, '1, '0);
    run_traffic(20);
    set_config('0, '1, '0, '1);
    run_traffic(20);
    set_config(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom));
    // writes to unused indexes must leave the settings alone
    write_reg(REG_SPARE_FIRST, CfgW'($urandom));
    write_reg(REG_SPARE_LAST, CfgW'($urandom));
    run_traffic(20);
    set_config(DEBOUNCE_RST, LONG_RST, REPEAT_RST, OVERPRESS_RST);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 35;
    recv_idle_pct = 47;
    run_traffic(170);
    set_config(CfgW'($urandom_range(0, 100)), CfgW'($urandom_range(0, 1000)),
               CfgW'($urandom_range(0, 300)), CfgW'($urandom_range(0, 4000)));
    send_idle_pct = 47;
    recv_idle_pct = 35;
    run_traffic(170);
    set_config(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(170);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.now_ms       = '0;
    in_if.button_down  = 1'b0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    model_cfg          = '{DEBOUNCE_RST, LONG_RST, REPEAT_RST, OVERPRESS_RST};
    model_held         = 1'b0;
    model_press_start  = '0;
    model_last_repeat  = '0;
    mismatch_count     = 0;
    polls_sent         = 0;
    send_idle_pct      = 35;
    recv_idle_pct      = 47;
    poll_clock         = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_settings();
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bpc_pkg.sv
rtl/bpc_if.sv
rtl/bpc_cfg_regs.sv
rtl/button_press_classifier.sv
rtl/bpc_checker.sv
dv/tb_button_press_classifier.sv
